FILE: src/b64se_pkg.sv
package b64se_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3d;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;
  } out_beat_t;

  // one group of up to three bytes waiting for the back end
  typedef struct packed {
    logic [23:0] group;
    logic [2:0]  nchars;
    logic        is_final;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

FILE: src/b64se_front.sv
module b64se_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  b64se_pkg::in_beat_t src_data,
  input  logic                q_full,
  output logic                q_push,
  output b64se_pkg::job_t     q_job
);

  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] count;
  logic       cnt_two;
  logic       accept;
  logic       store_only;

  assign cnt_two    = count[1];
  assign src_ready  = ~q_full;
  assign accept     = src_valid & src_ready;
  assign store_only = ~src_data.is_final & ~cnt_two;
  assign q_push     = accept & ~store_only;

  always_comb begin
    q_job.is_final = src_data.is_final;
    if (cnt_two) begin
      q_job.group  = {pend0, pend1, src_data.data_byte};
      q_job.nchars = 3'd4;
    end else if (count[0]) begin
      q_job.group  = {pend0, src_data.data_byte, 8'h00};
      q_job.nchars = 3'd3;
    end else begin
      q_job.group  = {src_data.data_byte, 16'h0000};
      q_job.nchars = 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (store_only) begin
        count <= count + 2'd1;
      end else begin
        count <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_only) begin
      if (count[0]) begin
        pend1 <= src_data.data_byte;
      end else begin
        pend0 <= src_data.data_byte;
      end
    end
  end

endmodule

FILE: src/b64se_queue.sv
module b64se_queue #(
  parameter int Depth = b64se_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64se_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output b64se_pkg::job_t pop_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64se_pkg::job_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] used;

  assign full      = (used == FullCnt);
  assign not_empty = (used != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        used <= used + CntW'(1);
      end else if (pop && !push) begin
        used <= used - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: src/b64se_back.sv
module b64se_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  b64se_pkg::job_t      q_job,
  output logic                 q_pop,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output b64se_pkg::out_beat_t dst_data
);

  b64se_pkg::job_t     cur;
  logic                cur_valid;
  logic [1:0]          idx;
  logic                adv;
  logic                last_char;
  logic [5:0]          sext;
  b64se_pkg::out_beat_t beat_next;

  assign adv       = cur_valid & (~dst_valid | dst_ready);
  assign last_char = (idx == 2'd3);
  assign q_pop     = q_valid & (~cur_valid | (adv & last_char));

  always_comb begin
    case (idx)
      2'd0:    sext = cur.group[23:18];
      2'd1:    sext = cur.group[17:12];
      2'd2:    sext = cur.group[11:6];
      default: sext = cur.group[5:0];
    endcase
    if ({1'b0, idx} < cur.nchars) begin
      beat_next.out_char = b64se_pkg::b64_char(sext);
    end else begin
      beat_next.out_char = b64se_pkg::PadChar;
    end
    beat_next.run_end     = last_char;
    beat_next.message_end = last_char & cur.is_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      dst_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (adv) begin
        idx <= idx + 2'd1;
        if (last_char) begin
          cur_valid <= 1'b0;
        end
      end
      if (adv) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (adv) begin
      dst_data <= beat_next;
    end
  end

endmodule

FILE: src/base64_stream_encoder.sv
// path: group queue slot, then current-group register, then output character register
// throughput: one byte per cycle while the group queue has room; one character per cycle out while dst_ready is high
// full groups give four characters out for every three bytes in, so the output side sets the pace
// reset: synchronous, active high; clears pending count, queue pointers and output valid
module base64_stream_encoder #(
  parameter int QueueDepth = b64se_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  b64se_pkg::in_beat_t  src_data,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output b64se_pkg::out_beat_t dst_data
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  b64se_pkg::job_t push_job;
  b64se_pkg::job_t pop_job;

  b64se_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (pop_job)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IdlePct = 17;
  localparam int HoldCycles = 80;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  b64se_pkg::in_beat_t src_data = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  b64se_pkg::out_beat_t dst_data;

  b64se_pkg::in_beat_t byte_q[$];
  b64se_pkg::out_beat_t char_q[$];

  string sym_table = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [7:0] held [2];
  int held_cnt = 0;

  int bytes_in = 0;
  int chars_out = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  logic steady;

  base64_stream_encoder DUT (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_data(dst_data)
  );

  always #2 clk = ~clk;

  // stretch with no idling on either side
  assign steady = (chars_out >= 8) && (chars_out < 48);

  task automatic encode_byte(input b64se_pkg::in_beat_t b);
    logic [23:0] grp;
    logic [5:0] sx;
    b64se_pkg::out_beat_t o;
    int nchars;
    if (!b.is_final && held_cnt < 2) begin
      held[held_cnt] = b.data_byte;
      held_cnt++;
    end else begin
      grp = '0;
      for (int k = 0; k < held_cnt; k++) grp[23 - 8 * k -: 8] = held[k];
      grp[23 - 8 * held_cnt -: 8] = b.data_byte;
      nchars = (held_cnt == 2) ? 4 : held_cnt + 2;
      for (int k = 0; k < 4; k++) begin
        sx = grp[23 - 6 * k -: 6];
        o.out_char = (k < nchars) ? sym_table[sx] : b64se_pkg::PadChar;
        o.run_end = (k == 3);
        o.message_end = (k == 3) && b.is_final;
        char_q = {char_q, o};
      end
      held_cnt = 0;
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic fin);
    b64se_pkg::in_beat_t b;
    b.data_byte = d;
    b.is_final = fin;
    byte_q = {byte_q, b};
  endtask

  task automatic add_message(input int len);
    for (int k = 0; k < len; k++) add_byte(8'($urandom_range(255)), k == len - 1);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && src_ready) begin
        encode_byte(src_data);
        bytes_in <= bytes_in + 1;
      end
      if ((!src_valid || src_ready) && byte_q.size() != 0 &&
          (steady || $urandom_range(99) >= IdlePct)) begin
        src_data <= byte_q.pop_front();
        src_valid <= 1'b1;
      end else if (src_valid && src_ready) begin
        src_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the stream is well under way
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_in >= 60) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    b64se_pkg::out_beat_t e;
    if (rst) begin
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= (hold_left <= 1) && (steady || $urandom_range(99) >= IdlePct);
      if (dst_valid && dst_ready) begin
        chars_out <= chars_out + 1;
        if (char_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected char beat: char=%h run_end=%b message_end=%b",
                     dst_data.out_char, dst_data.run_end, dst_data.message_end);
        end else begin
          e = char_q.pop_front();
          if (dst_data.out_char !== e.out_char || dst_data.run_end !== e.run_end ||
              dst_data.message_end !== e.message_end) begin
            errors++;
            if (errors <= 10)
              $display("char beat %0d: expected %h/%b/%b, got %h/%b/%b",
                       chars_out, e.out_char, e.run_end, e.message_end,
                       dst_data.out_char, dst_data.run_end, dst_data.message_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("base64_stream_encoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int len;
    // single bytes at the extremes
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    // two-byte messages
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b1);
    // full groups closed by the final byte
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    // full group then one or two leftover bytes
    add_byte(8'hfc, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'hf0, 1'b0);
    add_byte(8'h0f, 1'b1);
    add_byte(8'hc0, 1'b0);
    add_byte(8'h3f, 1'b0);
    add_byte(8'h5a, 1'b0);
    add_byte(8'ha5, 1'b0);
    add_byte(8'h80, 1'b1);
    while (byte_q.size() < 100) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      add_message(len);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || src_valid) @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0 && char_q.size() == 0) begin
      $display("base64_stream_encoder verification clean");
    end else begin
      $display("base64_stream_encoder verification failed");
    end
    $finish;
  end

endmodule
